/* design/tlpr_pkg.sv */
// Package for the thin-lens phase rotator: constants, shared types, arctangent table.
// No dependencies.
`default_nettype none
package tlpr_pkg;

   localparam int MAX_GRID      = 1024;
   localparam int CORDIC_STAGES = 16;
   localparam int SAMPLE_BITS   = 16;

   // field and register widths
   localparam int GRID_W  = 11;
   localparam int GAIN_W  = 48;
   localparam int SHIFT_W = 20;
   localparam int CSR_W   = GAIN_W;
   localparam int IDX_W   = 3;

   // register indexes
   localparam logic [IDX_W-1:0] REG_GRID_SIZE  = 3'd0;
   localparam logic [IDX_W-1:0] REG_PHASE_GAIN = 3'd1;
   localparam logic [IDX_W-1:0] REG_X_SHIFT    = 3'd2;
   localparam logic [IDX_W-1:0] REG_Y_SHIFT    = 3'd3;
   localparam logic [IDX_W-1:0] REG_SPHERICAL  = 3'd4;

   // counters and offsets
   localparam int CNT_W   = $clog2(MAX_GRID);
   localparam int OFF_W   = CNT_W + 2 + 8 + 1;        // signed pixel offset, 8 frac bits
   localparam int SUM_W   = 2 * OFF_W;                // u*u + v*v
   localparam int SPLIT   = SUM_W / 2;                // low half of sum for partial products
   localparam int GAIN_LO = 24;                       // low part of phase_gain
   localparam int ACC_W   = 56;                       // product kept modulo 2^56
   localparam int PHASE_W = 32;

   // shared multiplier
   localparam int MUL_W = 32;

   // cordic datapath
   localparam int X_W       = SAMPLE_BITS + 20;
   localparam int Z_W       = PHASE_W + 2;
   localparam int ITER_W    = $clog2(CORDIC_STAGES + 1);
   localparam int TABLE_LEN = 24;
   localparam logic [MUL_W-1:0] INV_GAIN = 32'd652032874;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef struct packed {
      logic [GRID_W-1:0]         grid_size;
      logic signed [GAIN_W-1:0]  phase_gain;
      logic signed [SHIFT_W-1:0] x_shift;
      logic signed [SHIFT_W-1:0] y_shift;
      logic                      spherical_mode;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic signed [OFF_W-1:0]       u;
      logic signed [OFF_W-1:0]       v;
      logic                          last;
      logic                          err;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROT,
      ST_DONE
   } back_state_type;

   // arctangent of 2^-i in turns, 32 fractional bits
   function automatic logic [PHASE_W-1:0] atan_turns(input logic [ITER_W-1:0] idx);
      logic [PHASE_W-1:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* design/tlpr_front.sv */
// Front end: raster counters and lens-centre offsets for each accepted beat.
// Depends on tlpr_pkg.
`default_nettype none
module tlpr_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic signed [tlpr_pkg::SAMPLE_BITS-1:0] re_in,
   input  wire logic signed [tlpr_pkg::SAMPLE_BITS-1:0] im_in,
   input  wire tlpr_pkg::cfg_type                  cfg,
   output tlpr_pkg::item_type                      item
);
   import tlpr_pkg::*;

   logic [CNT_W-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  col_ff, col_in;
   logic [GRID_W-1:0] n_eff;
   logic [GRID_W-1:0] n_m1;
   logic [GRID_W-1:0] half;
   logic              col_end, row_end;
   logic signed [OFF_W-1:0] row_d, col_d;

   // clamp grid size to the supported range
   always_comb begin
      n_eff = cfg.grid_size;
      if (cfg.grid_size < GRID_W'(2))
         n_eff = GRID_W'(2);
      else if (cfg.grid_size > GRID_W'(MAX_GRID))
         n_eff = GRID_W'(MAX_GRID);
      n_m1 = n_eff - GRID_W'(1);
      half = n_eff >> 1;
   end

   assign col_end = {1'b0, col_ff} >= n_m1;
   assign row_end = {1'b0, row_ff} >= n_m1;

   // offsets from lens centre, 8 fractional bits
   always_comb begin
      row_d = signed'(OFF_W'({1'b0, row_ff})) - signed'(OFF_W'(half));
      col_d = signed'(OFF_W'({1'b0, col_ff})) - signed'(OFF_W'(half));
      item.re   = re_in;
      item.im   = im_in;
      item.u    = (row_d <<< 8) - OFF_W'(cfg.x_shift);
      item.v    = (col_d <<< 8) - OFF_W'(cfg.y_shift);
      item.last = col_end && row_end;
      item.err  = cfg.spherical_mode;
   end

   // raster advance
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule
`default_nettype wire

/* design/tlpr_fifo.sv */
// Short queue between front and back ends.
// Depends on tlpr_pkg.
`default_nettype none
module tlpr_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tlpr_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output tlpr_pkg::item_type     head,
   output logic                   empty
);
   import tlpr_pkg::*;

   item_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;

   assign full  = cnt_ff == (QPTR_W+1)'(QDEPTH);
   assign empty = cnt_ff == '0;
   assign head  = mem_ff[rd_ff];

   // pointer and fill count
   always_comb begin
      wr_in  = (push && !full) ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = (pop && !empty) ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full)
         mem_ff[wr_ff] <= push_item;
   end

endmodule
`default_nettype wire

/* design/tlpr_back.sv */
// Back end: phase product over a shared 32x32 multiplier, CORDIC rotation, output register.
// Depends on tlpr_pkg.
`default_nettype none
module tlpr_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic signed [tlpr_pkg::GAIN_W-1:0] phase_gain,
   input  wire tlpr_pkg::item_type      head,
   input  wire logic                    q_empty,
   output logic                         q_pop,
   input  wire logic                    rsp_pop,
   output logic                         rsp_empty,
   output logic signed [tlpr_pkg::SAMPLE_BITS-1:0] re_out,
   output logic signed [tlpr_pkg::SAMPLE_BITS-1:0] im_out,
   output logic                         frame_last,
   output logic                         error
);
   import tlpr_pkg::*;

   localparam logic signed [X_W-1:0] SAT_HI = X_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [X_W-1:0] SAT_LO = -SAT_HI - X_W'(1);

   back_state_type           state_ff, state_in;
   logic [2:0]               step_ff, step_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   item_type                 item_ff, item_in;
   logic [SUM_W-1:0]         s_ff, s_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic signed [X_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]    z_ff, z_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] re_ff, re_in, im_ff, im_in;
   logic                     last_ff, last_in, err_ff, err_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_p;
   logic signed [X_W-1:0]    scaled;
   logic [PHASE_W-1:0]       phase, phase_f;
   logic                     fold;
   logic signed [X_W-1:0]    dx, dy, rx, ry;
   logic signed [Z_W-1:0]    at;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         3'd0: begin
            mul_a = MUL_W'(item_ff.u);
            mul_b = MUL_W'(item_ff.u);
         end
         3'd1: begin
            mul_a = MUL_W'(item_ff.v);
            mul_b = MUL_W'(item_ff.v);
         end
         3'd2: begin
            mul_a = signed'(MUL_W'(phase_gain[GAIN_LO-1:0]));
            mul_b = signed'(MUL_W'(s_ff[SPLIT-1:0]));
         end
         3'd3: begin
            mul_a = signed'(MUL_W'(phase_gain[GAIN_LO-1:0]));
            mul_b = signed'(MUL_W'(s_ff[SUM_W-1:SPLIT]));
         end
         3'd4: begin
            mul_a = MUL_W'(signed'(phase_gain[GAIN_W-1:GAIN_LO]));
            mul_b = signed'(MUL_W'(s_ff[SPLIT-1:0]));
         end
         3'd5: begin
            mul_a = MUL_W'(signed'(phase_gain[GAIN_W-1:GAIN_LO]));
            mul_b = signed'(MUL_W'(s_ff[SUM_W-1:SPLIT]));
         end
         3'd6: begin
            mul_a = MUL_W'(item_ff.re);
            mul_b = signed'(INV_GAIN);
         end
         3'd7: begin
            mul_a = MUL_W'(item_ff.im);
            mul_b = signed'(INV_GAIN);
         end
         default: ;
      endcase
   end

   assign mul_p  = mul_a * mul_b;
   assign scaled = X_W'(mul_p >>> 14);

   // quadrant fold of the phase
   always_comb begin
      phase   = acc_ff[ACC_W-1:ACC_W-PHASE_W];
      phase_f = phase + 32'h4000_0000;
      fold    = phase_f[PHASE_W-1];
   end

   // one CORDIC micro-rotation
   always_comb begin
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      at = signed'(Z_W'(atan_turns(iter_ff)));
   end

   // output rounding, half up, then saturate
   always_comb begin
      rx = (x_ff + X_W'(32768)) >>> 16;
      ry = (y_ff + X_W'(32768)) >>> 16;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      iter_in      = iter_ff;
      item_in      = item_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      re_in        = re_ff;
      im_in        = im_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               item_in  = head;
               step_in  = '0;
               state_in = head.err ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: s_in   = SUM_W'(mul_p);
               3'd1: s_in   = s_ff + SUM_W'(mul_p);
               3'd2: acc_in = ACC_W'(mul_p);
               3'd3: acc_in = acc_ff + (ACC_W'(mul_p) << SPLIT);
               3'd4: acc_in = acc_ff + (ACC_W'(mul_p) << GAIN_LO);
               3'd5: acc_in = acc_ff + (ACC_W'(mul_p) << (GAIN_LO + SPLIT));
               3'd6: x_in   = scaled;
               default: begin
                  x_in     = fold ? -x_ff : x_ff;
                  y_in     = fold ? -scaled : scaled;
                  z_in     = Z_W'(signed'(fold ? phase - 32'h8000_0000 : phase));
                  iter_in  = '0;
                  state_in = ST_ROT;
               end
            endcase
         end
         ST_ROT: begin
            if (!z_ff[Z_W-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + at;
            end
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(CORDIC_STAGES - 1))
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               last_in      = item_ff.last;
               err_in       = item_ff.err;
               if (item_ff.err) begin
                  re_in = item_ff.re;
                  im_in = item_ff.im;
               end else begin
                  re_in = (rx > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                          (rx < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(rx);
                  im_in = (ry > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                          (ry < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(ry);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      item_ff <= item_in;
      s_ff    <= s_in;
      acc_ff  <= acc_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      re_ff   <= re_in;
      im_ff   <= im_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_empty  = !out_valid_ff;
   assign re_out     = re_ff;
   assign im_out     = im_ff;
   assign frame_last = last_ff;
   assign error      = err_ff;

endmodule
`default_nettype wire

/* design/thin_lens_phase_rotator.sv */
// Top level of the thin-lens phase rotator: CSRs, front end, queue, back end.
// Depends on tlpr_pkg, tlpr_front, tlpr_fifo, tlpr_back.
//
//   channel | ports                               | handshake
//   --------+-------------------------------------+------------------------
//   req     | req_re_in, req_im_in                | push / full
//   rsp     | rsp_re_out, rsp_im_out, rsp_frame_last, rsp_error | pop / empty
//   csr     | csr_index, csr_wdata                | csr_wr_en, no wait
//
// For each lens beat the back end takes the beat from the queue, runs 8 steps of the
// shared 32x32 multiplier and CORDIC_STAGES CORDIC iterations, then loads the output
// register once it is free; spherical beats skip the multiplier and the CORDIC. It
// handles one beat at a time. Up to four beats queue between the front and back ends.
// Synchronous active-high reset empties the queue and clears the raster counters;
// CSRs return to their defaults. A stalled result holds in the output register.
`default_nettype none
module thin_lens_phase_rotator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire logic signed [tlpr_pkg::SAMPLE_BITS-1:0] req_re_in,
   input  wire logic signed [tlpr_pkg::SAMPLE_BITS-1:0] req_im_in,
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output logic signed [tlpr_pkg::SAMPLE_BITS-1:0] rsp_re_out,
   output logic signed [tlpr_pkg::SAMPLE_BITS-1:0] rsp_im_out,
   output logic                                    rsp_frame_last,
   output logic                                    rsp_error,
   input  wire logic                               csr_wr_en,
   input  wire logic [tlpr_pkg::IDX_W-1:0]         csr_index,
   input  wire logic [tlpr_pkg::CSR_W-1:0]         csr_wdata
);
   import tlpr_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type front_item, head;
   logic     accept, q_empty, q_pop;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_GRID_SIZE:  cfg_in.grid_size      = csr_wdata[GRID_W-1:0];
            REG_PHASE_GAIN: cfg_in.phase_gain     = csr_wdata[GAIN_W-1:0];
            REG_X_SHIFT:    cfg_in.x_shift        = csr_wdata[SHIFT_W-1:0];
            REG_Y_SHIFT:    cfg_in.y_shift        = csr_wdata[SHIFT_W-1:0];
            REG_SPHERICAL:  cfg_in.spherical_mode = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_size      <= GRID_W'(256);
         cfg_ff.phase_gain     <= '0;
         cfg_ff.x_shift        <= '0;
         cfg_ff.y_shift        <= '0;
         cfg_ff.spherical_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept = req_push && !req_full;

   tlpr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .re_in  (req_re_in),
      .im_in  (req_im_in),
      .cfg    (cfg_ff),
      .item   (front_item)
   );

   tlpr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_item),
      .full      (req_full),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty)
   );

   tlpr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .phase_gain (cfg_ff.phase_gain),
      .head       (head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .re_out     (rsp_re_out),
      .im_out     (rsp_im_out),
      .frame_last (rsp_frame_last),
      .error      (rsp_error)
   );

endmodule
`default_nettype wire

/* design/tlpr_checker.sv */
// Port-level checks for the thin-lens phase rotator, bound to the top level.
// Depends on tlpr_pkg and thin_lens_phase_rotator.
`default_nettype none
module tlpr_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_push,
   input wire logic                               req_full,
   input wire logic                               rsp_empty,
   input wire logic                               rsp_pop,
   input wire logic signed [tlpr_pkg::SAMPLE_BITS-1:0] rsp_re_out,
   input wire logic                               rsp_frame_last,
   input wire logic                               rsp_error
);
   import tlpr_pkg::*;

   // reset empties both sides
   a_reset_clears: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queue state not cleared by reset");

   // with no beat pushed in the first cycle out of reset, no result appears in the next one
   a_no_early_result: assert property (@(posedge clock) (reset ##1 !req_push) |=> rsp_empty)
      else $error("result appeared without a beat");

   // a full queue needs beats pushed since reset
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(req_full)) |-> $past(req_push))
      else $error("queue went full without a push");

   // a held result keeps rsp_re_out, rsp_frame_last and rsp_error stable
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_re_out) && $stable(rsp_frame_last) && $stable(rsp_error)))
      else $error("held result changed");

endmodule

bind thin_lens_phase_rotator tlpr_checker u_tlpr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_push       (req_push),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_re_out     (rsp_re_out),
   .rsp_frame_last (rsp_frame_last),
   .rsp_error      (rsp_error)
);
`default_nettype wire
